[hw/rtl/bounded_stack_with_search_core_macros.svh]
// assertion helpers for the stack core
`ifndef BOUNDED_STACK_WITH_SEARCH_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and codes of the bounded stack with membership search.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/bss_mem.sv]
// ----------------------------------------------------------------------------
// bss_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire  [AW-1:0]       waddr,
  input  bss_pkg::word_t      wdata,
  input  wire                 re,
  input  wire  [AW-1:0]       raddr,
  output bss_pkg::word_t      rdata
);

  bss_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bounded_stack_with_search_core.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// LIFO stack of signed words held in a synchronous memory, with push, pop,
// clear and a linear membership search over the held entries.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   -------------------   -----------------------------------------
//   in        in_valid / in_stall   action, value
//   out       out_valid / out_stall status, popped_value, found, fill_level
//
// push, clear, full push and empty pop/search: result follows in the next cycle
// pop: the top entry comes through the memory's registered read port
// search: one memory read per cycle, bottom entry first, until the key
//   matches or the top entry has been compared
// reset clears the fill count, state and out_valid; entry contents stay undefined until pushed
// a stalled result holds the block; the next request waits until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search_core #(
  parameter int DEPTH = 128
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire  [1:0]      action,
  input  bss_pkg::word_t  value,
  output logic            out_valid,
  input  wire             out_stall,
  output logic [1:0]      status,
  output bss_pkg::word_t  popped_value,
  output logic            found,
  output logic [7:0]      fill_level
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]     state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [AW-1:0]  cmp_idx, cmp_idx_next;
  bss_pkg::word_t key;

  logic           accept;
  logic           full;
  logic           hit;
  logic           last;
  logic           load;
  logic [1:0]     ld_status;
  bss_pkg::word_t ld_popped;
  logic           ld_found;

  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  bss_pkg::word_t mem_rdata;

  bss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count)),
    .wdata (value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign hit      = (mem_rdata == key);
  assign last     = (cmp_idx == AW'(count - CW'(1)));

  always_comb begin
    state_next   = state;
    count_next   = count;
    cmp_idx_next = cmp_idx;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    load         = 1'b0;
    ld_status    = bss_pkg::ST_OK;
    ld_popped    = '0;
    ld_found     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            bss_pkg::ACT_PUSH: begin
              load = 1'b1;
              if (full) begin
                ld_status = bss_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            bss_pkg::ACT_POP: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = bss_pkg::ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                mem_re     = 1'b1;
                mem_raddr  = AW'(count - CW'(1));
                state_next = S_POP;
              end
            end
            bss_pkg::ACT_CLEAR: begin
              load       = 1'b1;
              count_next = '0;
            end
            bss_pkg::ACT_SEARCH: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = bss_pkg::ST_EMPTY;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = '0;
                cmp_idx_next = '0;
                state_next   = S_SCAN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        load       = 1'b1;
        ld_popped  = mem_rdata;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        // stop on the first match or after the top entry
        if (hit || last) begin
          load       = 1'b1;
          ld_found   = hit;
          state_next = S_IDLE;
        end else begin
          mem_re       = 1'b1;
          mem_raddr    = cmp_idx + AW'(1);
          cmp_idx_next = cmp_idx + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    if (accept) begin
      key <= value;
    end
    if (load) begin
      status       <= ld_status;
      popped_value <= ld_popped;
      found        <= ld_found;
      fill_level   <= 8'(count_next);
    end
  end

`include "bounded_stack_with_search_core_macros.svh"

  `BSS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "fill count above depth")
  `BSS_ASSERT_NOW(a_busy_stalls, state != S_IDLE, in_stall, "request taken while busy")
  `BSS_ASSERT_NOW(a_load_free, load, !out_valid || !out_stall, "result overwrites held result")
  `BSS_ASSERT_NEXT(a_pop_read, accept && action == bss_pkg::ACT_POP && count != '0,
    state == S_POP, "pop did not wait for read data")

endmodule

`default_nettype wire
